### sv/ccc_pkg.sv
// Shared types, constants and letter-shift helpers for the classical cipher cascade.
// Used by every module under sv/; depends on nothing.
package ccc_pkg;

  localparam int ByteW          = 8;
  localparam int LenW           = 5;
  localparam int ShiftW         = 5;
  localparam int CfgIdxW        = 3;
  localparam int CfgDataW       = 64;
  localparam int LoBytes        = 8;
  localparam int KeyBytesDefault = 16;
  localparam int QueueDepth     = 2;

  localparam logic [ShiftW-1:0] Alphabet = 5'd26;
  localparam logic [ByteW-1:0]  UpperA   = 8'h41;
  localparam logic [ByteW-1:0]  UpperZ   = 8'h5a;
  localparam logic [ByteW-1:0]  LowerA   = 8'h61;
  localparam logic [ByteW-1:0]  LowerZ   = 8'h7a;
  localparam logic [ByteW-1:0]  CaseGap  = 8'h20;
  localparam logic [ByteW:0]    VigBias  = 9'd13;
  // 79 / 2048 sits just above 1/26: exact quotient for the small range used here
  localparam logic [6:0]        Recip26  = 7'd79;
  localparam int                RecipSh  = 11;

  typedef logic [ByteW-1:0] byte_t;

  typedef enum logic [CfgIdxW-1:0] {
    RegCaesarShift = 3'd0,
    RegDecryptMode = 3'd1,
    RegVigKeyLo    = 3'd2,
    RegVigKeyHi    = 3'd3,
    RegVigKeyLen   = 3'd4,
    RegXorKeyLo    = 3'd5,
    RegXorKeyHi    = 3'd6,
    RegXorKeyLen   = 3'd7
  } cfg_reg_e;

  // Mode settings shared by the front and back halves
  typedef struct packed {
    logic [ShiftW-1:0] caesar_shift;
    logic              decrypt_mode;
  } mode_cfg_t;

  // One classified beat waiting for the back half
  typedef struct packed {
    byte_t             data;
    byte_t             mask;
    logic [ShiftW-1:0] vig_shift;
  } entry_t;

  function automatic logic is_upper(input byte_t c);
    return (c >= UpperA) && (c <= UpperZ);
  endfunction

  function automatic logic is_lower(input byte_t c);
    return (c >= LowerA) && (c <= LowerZ);
  endfunction

  function automatic logic is_letter(input byte_t c);
    return is_upper(c) || is_lower(c);
  endfunction

  // Reduce a value below twice the alphabet size
  function automatic logic [ShiftW-1:0] wrap26(input logic [ShiftW:0] x);
    logic [ShiftW:0] r;
    begin
      r = (x >= {1'b0, Alphabet}) ? (x - {1'b0, Alphabet}) : x;
      return r[ShiftW-1:0];
    end
  endfunction

  // Vigenere shift of a key byte: uppercase, minus 'A', modulo 26
  function automatic logic [ShiftW-1:0] vig_shift(input byte_t k);
    byte_t            ku;
    logic [ByteW:0]   x;
    logic [15:0]      prod;
    logic [4:0]       q;
    logic [ByteW:0]   r;
    begin
      ku   = is_lower(k) ? (k - CaseGap) : k;
      x    = {1'b0, ku} + VigBias;
      prod = 16'(x) * 16'(Recip26);
      q    = prod[RecipSh +: 5];
      r    = x - (9'(q) * 9'(Alphabet));
      if (r >= {4'd0, Alphabet}) begin
        r = r - {4'd0, Alphabet};
      end
      return r[ShiftW-1:0];
    end
  endfunction

  // Rotate a letter within its case; any other byte passes unchanged
  function automatic byte_t shift_letter(input byte_t c, input logic [ShiftW-1:0] s);
    byte_t             base;
    byte_t             off;
    logic [ShiftW-1:0] rot;
    begin
      base = is_upper(c) ? UpperA : LowerA;
      off  = c - base;
      rot  = wrap26({1'b0, off[ShiftW-1:0]} + {1'b0, s});
      return is_letter(c) ? (base + byte_t'(rot)) : c;
    end
  endfunction

endpackage

### sv/ccc_front.sv
// Front half: accepts input beats, tracks key positions and classifies each byte.
// Depends on ccc_pkg; feeds ccc_queue.
module ccc_front #(
  parameter int KEY_BYTES = ccc_pkg::KeyBytesDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  ccc_pkg::byte_t                        data_byte_i,
  input  ccc_pkg::byte_t                        pad_byte_i,
  input  logic                                  first_of_message_i,
  input  ccc_pkg::mode_cfg_t                    mode_i,
  input  logic [KEY_BYTES-1:0][ccc_pkg::ByteW-1:0] vig_key_i,
  input  logic [ccc_pkg::LenW-1:0]              vig_len_i,
  input  logic [KEY_BYTES-1:0][ccc_pkg::ByteW-1:0] xor_key_i,
  input  logic [ccc_pkg::LenW-1:0]              xor_len_i,
  input  logic                                  q_full_i,
  output logic                                  push_o,
  output ccc_pkg::entry_t                       push_entry_o
);

  localparam int PosW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam logic [ccc_pkg::LenW-1:0] MaxLen = ccc_pkg::LenW'(KEY_BYTES);

  logic [PosW-1:0]         vig_pos_q, vig_pos_d;
  logic [PosW-1:0]         xor_pos_q, xor_pos_d;
  logic [ccc_pkg::LenW-1:0] vig_len_eff, xor_len_eff;
  logic [PosW-1:0]         vig_cur, xor_cur, vig_idx, xor_idx;
  logic [PosW-1:0]         vig_adv, xor_adv;
  logic                    vig_apply, xor_apply;
  ccc_pkg::byte_t          xor_byte, mask, vig_in;
  logic                    accept;

  // Clamp oversized key lengths
  assign vig_len_eff = (vig_len_i > MaxLen) ? MaxLen : vig_len_i;
  assign xor_len_eff = (xor_len_i > MaxLen) ? MaxLen : xor_len_i;

  // Restart positions on a new message, fall back to zero on a stale position
  assign vig_cur = first_of_message_i ? '0 : vig_pos_q;
  assign xor_cur = first_of_message_i ? '0 : xor_pos_q;
  assign vig_idx = (ccc_pkg::LenW'(vig_cur) < vig_len_eff) ? vig_cur : '0;
  assign xor_idx = (ccc_pkg::LenW'(xor_cur) < xor_len_eff) ? xor_cur : '0;
  assign vig_adv = ((ccc_pkg::LenW'(vig_idx) + 1'b1) >= vig_len_eff) ? '0 : (vig_idx + 1'b1);
  assign xor_adv = ((ccc_pkg::LenW'(xor_idx) + 1'b1) >= xor_len_eff) ? '0 : (xor_idx + 1'b1);

  // Fold repeating key and pad into one mask
  assign xor_apply = (xor_len_eff != '0);
  assign xor_byte  = xor_apply ? xor_key_i[xor_idx] : '0;
  assign mask      = xor_byte ^ pad_byte_i;

  // Letter test at the Vigenere stage; Caesar keeps letters letters
  assign vig_in    = mode_i.decrypt_mode ? (data_byte_i ^ mask) : data_byte_i;
  assign vig_apply = (vig_len_eff != '0) && ccc_pkg::is_letter(vig_in);

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign push_o     = accept;

  always_comb begin
    push_entry_o.data      = data_byte_i;
    push_entry_o.mask      = mask;
    push_entry_o.vig_shift = vig_apply ? ccc_pkg::vig_shift(vig_key_i[vig_idx]) : '0;
  end

  // Update positions on each accepted beat; the Vigenere position advances only on letters
  always_comb begin
    vig_pos_d = vig_pos_q;
    xor_pos_d = xor_pos_q;
    if (accept) begin
      vig_pos_d = vig_apply ? vig_adv : vig_cur;
      xor_pos_d = xor_apply ? xor_adv : xor_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vig_pos_q <= '0;
      xor_pos_q <= '0;
    end else begin
      vig_pos_q <= vig_pos_d;
      xor_pos_q <= xor_pos_d;
    end
  end

  a_vig_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ccc_pkg::LenW'(vig_pos_q) < MaxLen))
    else $error("Vigenere position beyond key storage");

  a_xor_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && first_of_message_i && (xor_len_eff > ccc_pkg::LenW'(1)))
      |=> (xor_pos_q == PosW'(1)))
    else $error("XOR position did not restart on first beat of message");

endmodule

### sv/ccc_queue.sv
// Short queue that decouples the classifying front from the shifting back.
// Depends on ccc_pkg for the entry type and depth.
module ccc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ccc_pkg::entry_t push_entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            pop_valid_o,
  output ccc_pkg::entry_t pop_entry_o
);

  localparam int PtrW = (ccc_pkg::QueueDepth > 1) ? $clog2(ccc_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(ccc_pkg::QueueDepth + 1);
  localparam logic [CntW-1:0] Depth = CntW'(ccc_pkg::QueueDepth);

  ccc_pkg::entry_t entries_q [ccc_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_pop;

  assign full_o      = (count_q == Depth);
  assign pop_valid_o = (count_q != '0);
  assign pop_entry_o = entries_q[rd_ptr_q];
  assign do_pop      = pop_i && pop_valid_o;

  // Step pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(ccc_pkg::QueueDepth - 1)) ? '0 : (wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(ccc_pkg::QueueDepth - 1)) ? '0 : (rd_ptr_q + 1'b1);
    end
    case ({push_i, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold entry payload; no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_entry_i;
    end
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= Depth))
    else $error("Queue fill level above depth");

  a_count_grow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("Queue lost a pushed beat");

endmodule

### sv/ccc_back.sv
// Back half: applies the combined letter shift and XOR mask, then holds the result.
// Depends on ccc_pkg; drains ccc_queue.
module ccc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ccc_pkg::mode_cfg_t mode_i,
  input  logic               q_valid_i,
  input  ccc_pkg::entry_t    q_entry_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ccc_pkg::byte_t     out_byte_o
);

  logic                         out_valid_q, out_valid_d;
  ccc_pkg::byte_t               out_byte_q;
  logic [ccc_pkg::ShiftW-1:0]   caesar_red, total, inv_total;
  ccc_pkg::byte_t               enc_byte, dec_byte, result;

  // Caesar and Vigenere shifts merge into one rotation
  assign caesar_red = ccc_pkg::wrap26({1'b0, mode_i.caesar_shift});
  assign total      = ccc_pkg::wrap26({1'b0, caesar_red} + {1'b0, q_entry_i.vig_shift});
  assign inv_total  = (total == '0) ? '0 : (ccc_pkg::Alphabet - total);

  assign enc_byte = ccc_pkg::shift_letter(q_entry_i.data, total) ^ q_entry_i.mask;
  assign dec_byte = ccc_pkg::shift_letter(q_entry_i.data ^ q_entry_i.mask, inv_total);
  assign result   = mode_i.decrypt_mode ? dec_byte : enc_byte;

  // Take a queued beat whenever the output register is free or draining
  assign pop_o       = q_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_d = pop_o ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_byte_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

endmodule

### sv/classical_cipher_cascade.sv
// Top level of the classical cipher cascade: configuration registers and the
// front / queue / back split. Depends on ccc_pkg, ccc_front, ccc_queue, ccc_back.
//
//   port group   direction  handshake               payload
//   input beat   in         in_valid_i/in_stall_o   data_byte_i, pad_byte_i, first_of_message_i
//   result beat  out        out_valid_o/out_stall_i out_byte_o
//   config       in         cfg_we_i                cfg_index_i, cfg_data_i
//
// One byte per cycle sustained while the output is not stalled; each input is classified
// into the two-entry queue, then shifted from there into the output register.
// in_stall_o rises only when the two-entry queue is full.
// Reset clears key positions, configuration and valid state at once; no clearing pass.
module classical_cipher_cascade #(
  parameter int KEY_BYTES = ccc_pkg::KeyBytesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    data_byte_i,
  input  logic [7:0]                    pad_byte_i,
  input  logic                          first_of_message_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    out_byte_o,
  input  logic                          cfg_we_i,
  input  logic [ccc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ccc_pkg::CfgDataW-1:0]  cfg_data_i
);

  ccc_pkg::mode_cfg_t                      mode_q;
  logic [KEY_BYTES-1:0][ccc_pkg::ByteW-1:0] vig_key_q, xor_key_q;
  logic [ccc_pkg::LenW-1:0]                vig_len_q, xor_len_q;
  ccc_pkg::cfg_reg_e                       reg_sel;
  logic                                    push, q_full, q_valid, pop;
  ccc_pkg::entry_t                         push_entry, pop_entry;

  assign reg_sel = ccc_pkg::cfg_reg_e'(cfg_index_i);

  // Load mode and length registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= '0;
      vig_len_q <= '0;
      xor_len_q <= '0;
    end else if (cfg_we_i) begin
      case (reg_sel)
        ccc_pkg::RegCaesarShift: mode_q.caesar_shift <= cfg_data_i[ccc_pkg::ShiftW-1:0];
        ccc_pkg::RegDecryptMode: mode_q.decrypt_mode <= cfg_data_i[0];
        ccc_pkg::RegVigKeyLen:   vig_len_q <= cfg_data_i[ccc_pkg::LenW-1:0];
        ccc_pkg::RegXorKeyLen:   xor_len_q <= cfg_data_i[ccc_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  // Load key bytes from the low or high word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vig_key_q <= '0;
      xor_key_q <= '0;
    end else if (cfg_we_i) begin
      for (int b = 0; b < KEY_BYTES; b++) begin
        if (((b < ccc_pkg::LoBytes) && (reg_sel == ccc_pkg::RegVigKeyLo)) ||
            ((b >= ccc_pkg::LoBytes) && (reg_sel == ccc_pkg::RegVigKeyHi))) begin
          vig_key_q[b] <= cfg_data_i[ccc_pkg::ByteW*(b % ccc_pkg::LoBytes) +: ccc_pkg::ByteW];
        end
        if (((b < ccc_pkg::LoBytes) && (reg_sel == ccc_pkg::RegXorKeyLo)) ||
            ((b >= ccc_pkg::LoBytes) && (reg_sel == ccc_pkg::RegXorKeyHi))) begin
          xor_key_q[b] <= cfg_data_i[ccc_pkg::ByteW*(b % ccc_pkg::LoBytes) +: ccc_pkg::ByteW];
        end
      end
    end
  end

  ccc_front #(
    .KEY_BYTES (KEY_BYTES)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .data_byte_i        (data_byte_i),
    .pad_byte_i         (pad_byte_i),
    .first_of_message_i (first_of_message_i),
    .mode_i             (mode_q),
    .vig_key_i          (vig_key_q),
    .vig_len_i          (vig_len_q),
    .xor_key_i          (xor_key_q),
    .xor_len_i          (xor_len_q),
    .q_full_i           (q_full),
    .push_o             (push),
    .push_entry_o       (push_entry)
  );

  ccc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .pop_valid_o  (q_valid),
    .pop_entry_o  (pop_entry)
  );

  ccc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .q_valid_i   (q_valid),
    .q_entry_i   (pop_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o)
  );

endmodule
